### rtl/rps_pkg.sv
package rps_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int PC_WIDTH    = 4;
    localparam int BIT_CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = CFG_INDEX_WIDTH'(1);

    localparam logic [VALUE_WIDTH-1:0] RANGE_LOW_RESET  = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] RANGE_HIGH_RESET = VALUE_WIDTH'(100);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SQUARE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_INC_D,
        OP_CLR_PRIME,
        OP_FINISH,
        OP_RESTART,
        OP_EXHAUST
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_RESTART,
        C_EXHAUSTED,
        C_NOT_PRIME,
        C_SQ_GT_C,
        C_BITS_LEFT,
        C_REM_ZERO
    } cond_t;

    typedef struct packed {
        op_t                 op;
        cond_t               cond;
        logic                hold;
        logic [PC_WIDTH-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic restart;
        logic exhausted;
        logic not_prime;
        logic sq_gt_c;
        logic bits_left;
        logic rem_zero;
        logic out_busy;
    } status_t;

    localparam logic [PC_WIDTH-1:0] PC_WAIT    = PC_WIDTH'(0);
    localparam logic [PC_WIDTH-1:0] PC_LOOP    = PC_WIDTH'(4);
    localparam logic [PC_WIDTH-1:0] PC_DIV     = PC_WIDTH'(6);
    localparam logic [PC_WIDTH-1:0] PC_COMPOS  = PC_WIDTH'(9);
    localparam logic [PC_WIDTH-1:0] PC_FINISH  = PC_WIDTH'(10);
    localparam logic [PC_WIDTH-1:0] PC_RESTART = PC_WIDTH'(11);
    localparam logic [PC_WIDTH-1:0] PC_EXHAUST = PC_WIDTH'(12);

    // microprogram: jump to target when cond holds, else fall through
    function automatic uword_t ucode(input logic [PC_WIDTH-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_WIDTH'(0):  w = '{OP_CAPTURE,   C_NO_ACCEPT, 1'b0, PC_WAIT};
            PC_WIDTH'(1):  w = '{OP_NONE,      C_RESTART,   1'b0, PC_RESTART};
            PC_WIDTH'(2):  w = '{OP_NONE,      C_EXHAUSTED, 1'b0, PC_EXHAUST};
            PC_WIDTH'(3):  w = '{OP_NONE,      C_NOT_PRIME, 1'b0, PC_FINISH};
            PC_WIDTH'(4):  w = '{OP_SQUARE,    C_NEXT,      1'b0, PC_WAIT};
            PC_WIDTH'(5):  w = '{OP_DIV_INIT,  C_SQ_GT_C,   1'b0, PC_FINISH};
            PC_WIDTH'(6):  w = '{OP_DIV_STEP,  C_BITS_LEFT, 1'b0, PC_DIV};
            PC_WIDTH'(7):  w = '{OP_NONE,      C_REM_ZERO,  1'b0, PC_COMPOS};
            PC_WIDTH'(8):  w = '{OP_INC_D,     C_ALWAYS,    1'b0, PC_LOOP};
            PC_WIDTH'(9):  w = '{OP_CLR_PRIME, C_ALWAYS,    1'b0, PC_FINISH};
            PC_WIDTH'(10): w = '{OP_FINISH,    C_ALWAYS,    1'b1, PC_WAIT};
            PC_WIDTH'(11): w = '{OP_RESTART,   C_ALWAYS,    1'b1, PC_WAIT};
            PC_WIDTH'(12): w = '{OP_EXHAUST,   C_ALWAYS,    1'b1, PC_WAIT};
            default:       w = '{OP_NONE,      C_ALWAYS,    1'b0, PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/rps_sequencer.sv
module rps_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  rps_pkg::status_t  status,
    output logic              s_ready,
    output rps_pkg::ctrl_t    ctrl
);

    logic [rps_pkg::PC_WIDTH-1:0] pc_reg;
    logic [rps_pkg::PC_WIDTH-1:0] pc_next;
    rps_pkg::uword_t              uw;
    logic                         accept;
    logic                         taken;
    logic                         stall;

    assign uw      = rps_pkg::ucode(pc_reg);
    assign s_ready = (pc_reg == rps_pkg::PC_WAIT);
    assign accept  = s_valid && s_ready;
    assign stall   = uw.hold && status.out_busy;

    always_comb begin
        unique case (uw.cond)
            rps_pkg::C_NEXT:      taken = 1'b0;
            rps_pkg::C_ALWAYS:    taken = 1'b1;
            rps_pkg::C_NO_ACCEPT: taken = !accept;
            rps_pkg::C_RESTART:   taken = status.restart;
            rps_pkg::C_EXHAUSTED: taken = status.exhausted;
            rps_pkg::C_NOT_PRIME: taken = status.not_prime;
            rps_pkg::C_SQ_GT_C:   taken = status.sq_gt_c;
            rps_pkg::C_BITS_LEFT: taken = status.bits_left;
            rps_pkg::C_REM_ZERO:  taken = status.rem_zero;
            default:              taken = 1'b0;
        endcase
    end

    always_comb begin
        priority if (stall) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = uw.target;
        end else begin
            pc_next = pc_reg + rps_pkg::PC_WIDTH'(1);
        end
    end

    always_comb begin
        ctrl.op = uw.op;
        if (uw.op == rps_pkg::OP_CAPTURE) begin
            ctrl.fire = accept;
        end else begin
            ctrl.fire = !stall;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rps_pkg::PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/rps_datapath.sv
module rps_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rps_pkg::ctrl_t                        ctrl,
    input  logic                                  s_restart,
    input  logic                                  cfg_we,
    input  logic [rps_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rps_pkg::VALUE_WIDTH-1:0]       cfg_wdata,
    input  logic                                  m_ready,
    output rps_pkg::status_t                      status,
    output logic                                  m_valid,
    output logic [rps_pkg::VALUE_WIDTH-1:0]       m_candidate,
    output logic                                  m_prime_flag,
    output logic [rps_pkg::COUNT_WIDTH-1:0]       m_prime_count,
    output logic                                  m_range_done
);

    localparam int VW = rps_pkg::VALUE_WIDTH;
    localparam int CW = rps_pkg::COUNT_WIDTH;
    localparam int BW = rps_pkg::BIT_CNT_WIDTH;

    logic [VW-1:0]   range_low_reg;
    logic [VW-1:0]   range_high_reg;
    logic [VW:0]     next_cand_reg;
    logic [CW-1:0]   count_reg;
    logic            finished_reg;

    logic            restart_reg;
    logic [VW-1:0]   cand_reg;
    logic            prime_reg;
    logic [VW-1:0]   div_reg;
    logic [2*VW-1:0] sq_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   shift_reg;
    logic [BW-1:0]   bit_cnt_reg;

    logic            m_valid_reg;
    logic [VW-1:0]   m_cand_reg;
    logic            m_prime_reg;
    logic [CW-1:0]   m_count_reg;
    logic            m_done_reg;

    logic [VW:0]     trial;
    logic [VW:0]     trial_diff;
    logic            out_busy;
    logic            fire;

    assign out_busy   = m_valid_reg && !m_ready;
    assign fire       = ctrl.fire;
    assign trial      = {rem_reg, shift_reg[VW-1]};
    assign trial_diff = trial - {1'b0, div_reg};

    always_comb begin
        status.restart   = restart_reg;
        status.exhausted = finished_reg || (next_cand_reg > {1'b0, range_high_reg});
        status.not_prime = !prime_reg;
        status.sq_gt_c   = sq_reg > {{VW{1'b0}}, cand_reg};
        status.bits_left = (bit_cnt_reg != '0);
        status.rem_zero  = (rem_reg == '0);
        status.out_busy  = out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= rps_pkg::RANGE_LOW_RESET;
            range_high_reg <= rps_pkg::RANGE_HIGH_RESET;
            next_cand_reg  <= {1'b0, rps_pkg::RANGE_LOW_RESET};
            count_reg      <= '0;
            finished_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == rps_pkg::REG_RANGE_LOW) begin
                    range_low_reg <= cfg_wdata;
                end else if (cfg_index == rps_pkg::REG_RANGE_HIGH) begin
                    range_high_reg <= cfg_wdata;
                end
            end
            if (fire && ((ctrl.op == rps_pkg::OP_FINISH) || (ctrl.op == rps_pkg::OP_RESTART)
                         || (ctrl.op == rps_pkg::OP_EXHAUST))) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                unique case (ctrl.op)
                    rps_pkg::OP_FINISH: begin
                        if (prime_reg && (count_reg != {CW{1'b1}})) begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (cand_reg == range_high_reg) begin
                            finished_reg <= 1'b1;
                        end else begin
                            next_cand_reg <= {1'b0, cand_reg} + (VW+1)'(1);
                        end
                    end
                    rps_pkg::OP_RESTART: begin
                        next_cand_reg <= {1'b0, range_low_reg};
                        count_reg     <= '0;
                        finished_reg  <= 1'b0;
                    end
                    rps_pkg::OP_EXHAUST: begin
                        finished_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            unique case (ctrl.op)
                rps_pkg::OP_CAPTURE: begin
                    restart_reg <= s_restart;
                    cand_reg    <= next_cand_reg[VW-1:0];
                    prime_reg   <= (next_cand_reg[VW:1] != '0);
                    div_reg     <= VW'(2);
                end
                rps_pkg::OP_SQUARE: begin
                    sq_reg <= div_reg * div_reg;
                end
                rps_pkg::OP_DIV_INIT: begin
                    rem_reg     <= '0;
                    shift_reg   <= cand_reg;
                    bit_cnt_reg <= BW'(VW - 1);
                end
                rps_pkg::OP_DIV_STEP: begin
                    if (!trial_diff[VW]) begin
                        rem_reg <= trial_diff[VW-1:0];
                    end else begin
                        rem_reg <= trial[VW-1:0];
                    end
                    shift_reg   <= {shift_reg[VW-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - BW'(1);
                end
                rps_pkg::OP_INC_D: begin
                    div_reg <= div_reg + VW'(1);
                end
                rps_pkg::OP_CLR_PRIME: begin
                    prime_reg <= 1'b0;
                end
                rps_pkg::OP_FINISH: begin
                    m_cand_reg  <= cand_reg;
                    m_prime_reg <= prime_reg;
                    m_count_reg <= (prime_reg && (count_reg != {CW{1'b1}}))
                                   ? count_reg + CW'(1) : count_reg;
                    m_done_reg  <= (cand_reg == range_high_reg);
                end
                rps_pkg::OP_RESTART: begin
                    m_cand_reg  <= range_low_reg;
                    m_prime_reg <= 1'b0;
                    m_count_reg <= '0;
                    m_done_reg  <= 1'b0;
                end
                rps_pkg::OP_EXHAUST: begin
                    m_cand_reg  <= '0;
                    m_prime_reg <= 1'b0;
                    m_count_reg <= count_reg;
                    m_done_reg  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_candidate   = m_cand_reg;
    assign m_prime_flag  = m_prime_reg;
    assign m_prime_count = m_count_reg;
    assign m_range_done  = m_done_reg;

endmodule

### rtl/prime_range_scanner_top.sv
// Flow to m_valid: a restart is checked first, then an exhausted range, then a candidate
// below two, which finishes as not prime; otherwise trial divisors d from 2 upward are tried
// while d*d <= candidate, each by a bit-serial remainder over all 16 candidate bits, until a
// divisor is found. Worst case is a prime near 65535; m_ready low holds the result.
// Throughput: one transaction at a time; a new one is taken once the sequencer is back in wait.
// Reset: aresetn synchronous active low; range_low=1, range_high=100, count cleared.
module prime_range_scanner_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_restart,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rps_pkg::VALUE_WIDTH-1:0]       m_candidate,
    output logic                                  m_prime_flag,
    output logic [rps_pkg::COUNT_WIDTH-1:0]       m_prime_count,
    output logic                                  m_range_done,
    input  logic                                  cfg_we,
    input  logic [rps_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rps_pkg::VALUE_WIDTH-1:0]       cfg_wdata
);

    rps_pkg::ctrl_t   ctrl;
    rps_pkg::status_t status;

    rps_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .s_ready (s_ready),
        .ctrl    (ctrl)
    );

    rps_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .s_restart     (s_restart),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_ready       (m_ready),
        .status        (status),
        .m_valid       (m_valid),
        .m_candidate   (m_candidate),
        .m_prime_flag  (m_prime_flag),
        .m_prime_count (m_prime_count),
        .m_range_done  (m_range_done)
    );

endmodule
